// ===== rtl/ready_queue_with_steal_assert.svh =====
// assertion macros shared by the queue rtl
`ifndef READY_QUEUE_WITH_STEAL_ASSERT_SVH
`define READY_QUEUE_WITH_STEAL_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RQS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define RQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rqs_pkg.sv =====
package rqs_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int ID_W            = 8;

  // operation codes
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_PICK  = 2'd1;
  localparam logic [1:0] OP_STEAL = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]      operation;
    logic [ID_W-1:0] task_id;
    logic            pinned;
  } in_word_t;

  typedef struct packed {
    logic [ID_W-1:0] result_id;
    logic [1:0]      status;
    logic [4:0]      occupancy;
  } out_word_t;

  // last unpinned entry seen further toward the tail
  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] id;
  } carry_t;

  // what a cell shows its lower neighbor
  typedef struct packed {
    logic            hit;
    logic [ID_W-1:0] id;
    logic            pinned;
    carry_t          carry;
  } cell_link_t;

  // commit strobes broadcast to every cell
  typedef struct packed {
    logic push;
    logic pick;
    logic steal;
  } cell_cmd_t;

endpackage

// ===== rtl/rqs_cell.sv =====
module rqs_cell
  import rqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int IDX         = 0
) (
  input  logic                             clk,
  input  cell_cmd_t                        cmd,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0] count,
  input  logic [ID_W-1:0]                  push_id,
  input  logic                             push_pinned,
  input  cell_link_t                       nbr,
  output cell_link_t                       link
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] MyIdx = CW'(IDX);

  logic [ID_W-1:0] id_r;
  logic            pin_r;
  carry_t          carry_r;
  carry_t          carry_nxt;
  logic            occ;

  assign occ = (MyIdx < count);

  // suffix search moves one cell per cycle toward the head
  always_comb begin
    if (nbr.carry.found) begin
      carry_nxt = nbr.carry;
    end else begin
      carry_nxt.found = nbr.hit;
      carry_nxt.id    = nbr.id;
    end
  end

  // entry update: load at tail, or take the neighbor to close a gap
  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
    if (cmd.push && (MyIdx == count)) begin
      id_r  <= push_id;
      pin_r <= push_pinned;
    end else if (cmd.pick || (cmd.steal && !carry_r.found)) begin
      id_r  <= nbr.id;
      pin_r <= nbr.pinned;
    end
  end

  assign link.hit    = occ && !pin_r;
  assign link.id     = id_r;
  assign link.pinned = pin_r;
  assign link.carry  = carry_r;

endmodule

// ===== rtl/ready_queue_with_steal.sv =====
// channel | dir | word       | handshake
// in_     | in  | in_word_t  | in_valid / in_stall
// out_    | out | out_word_t | out_valid / out_stall
//
// push and pick commit once the word is held in in_r; a steal first counts
// cnt_r down from ScanWait, the time the tail-to-head search needs to ripple
// through the row of cells, one cell a cycle.
// one word is worked on at a time; the result waits in an output register, so
// the next word is taken while it waits; a commit holds while it is stalled.
// reset clears the count and control; entry contents stay undefined.
module ready_queue_with_steal
  import rqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  `include "ready_queue_with_steal_assert.svh"

  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int TW  = $clog2(QUEUE_DEPTH);
  localparam logic [CW-1:0] Full     = CW'(QUEUE_DEPTH);
  localparam logic [TW-1:0] ScanWait = TW'(QUEUE_DEPTH - 1);

  in_word_t   in_r;
  logic       busy_r;
  logic [TW-1:0] cnt_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic       out_valid_r;
  out_word_t  out_r;
  out_word_t  res;
  logic       in_acc;
  logic       commit;
  logic       found;
  logic [ID_W-1:0] steal_id;
  cell_cmd_t  cmd;
  cell_link_t links [0:QUEUE_DEPTH];

  assign in_acc = in_valid && !in_stall;
  assign in_stall = busy_r;
  assign commit = busy_r && (cnt_r == '0) && !(out_valid_r && out_stall);

  // row of cells, the top one sees an empty neighbor
  assign links[QUEUE_DEPTH] = '0;
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    rqs_cell #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .IDX        (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count_r),
      .push_id    (in_r.task_id),
      .push_pinned(in_r.pinned),
      .nbr        (links[g+1]),
      .link       (links[g])
    );
  end

  // steal target as seen from the head cell
  assign found    = links[0].carry.found || links[0].hit;
  assign steal_id = links[0].carry.found ? links[0].carry.id : links[0].id;

  // decode the pending operation
  always_comb begin
    cmd           = '0;
    count_nxt     = count_r;
    res.result_id = '0;
    res.status    = ST_DONE;
    case (in_r.operation)
      OP_PUSH: begin
        if (count_r == Full) begin
          res.status = ST_FULL;
        end else begin
          cmd.push  = commit;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_PICK: begin
        if (count_r == '0) begin
          res.status = ST_NONE;
        end else begin
          cmd.pick      = commit;
          count_nxt     = count_r - 1'b1;
          res.result_id = links[0].id;
        end
      end
      OP_STEAL: begin
        if (!found) begin
          res.status = ST_NONE;
        end else begin
          cmd.steal     = commit;
          count_nxt     = count_r - 1'b1;
          res.result_id = steal_id;
        end
      end
      default: begin
      end
    endcase
    res.occupancy = 5'(count_nxt);
  end

  // control and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_r <= 1'b1;
        cnt_r  <= (in_word.operation == OP_STEAL) ? ScanWait : '0;
      end else if (commit) begin
        busy_r <= 1'b0;
      end else if (busy_r && (cnt_r != '0)) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_word;
    end
    if (commit) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  `RQS_ASSERT_NOW(a_count_bound, 1'b1, count_r <= Full, "count above depth")
  `RQS_ASSERT_NOW(a_no_overwrite, commit, !(out_valid_r && out_stall),
                  "commit over a stalled result")
  `RQS_ASSERT_NEXT(a_pick_dec, commit && (in_r.operation == OP_PICK) && (count_r != '0),
                   count_r == $past(count_r) - 1'b1, "pick did not remove an entry")
  `RQS_ASSERT_NEXT(a_commit_out, commit, out_valid_r, "commit without result")

endmodule
